// File: rtl/bba_pkg.sv
// Shared types and constants of the buddy block allocator core.
// Depends on nothing; the controller, datapath and top level refer to it by scoped names.
package bba_pkg;

  // Fixed field widths of the stream payload.
  localparam int SIZE_W      = 6;
  localparam int OFFSET_W    = 31;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  // Operation selector carried in the input tuser.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_TOO_SMALL = 3'd1,
    ST_NONE_FREE = 3'd2,
    ST_FREED     = 3'd3,
    ST_NULL_FREE = 3'd4,
    ST_BAD_ORDER = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_POP,
    S_SPLIT,
    S_FREE,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    step_up;
    logic    pop_rd;
    logic    pop_wr;
    logic    split;
    logic    free_wr;
    logic    out_load;
    status_t status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free;
    logic present;
    logic size_small;
    logic size_big;
    logic head_nz;
    logic lst_zero;
    logic split_more;
    logic last_split;
    logic out_room;
  } dp_stat_t;

endpackage

// File: rtl/bba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/bba_ctrl.sv
// Controller state machine of the buddy block allocator core.
// Depends on bba_pkg for the state, status, command and status-bundle types.
module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t  cmd
);

  bba_pkg::state_t  state, state_next;
  bba_pkg::status_t result, result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bba_pkg::S_IDLE;
      result <= bba_pkg::ST_ALLOCATED;
    end else begin
      state  <= state_next;
      result <= result_next;
    end
  end

  always_comb begin
    state_next    = state;
    result_next   = result;
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      bba_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = bba_pkg::S_CHECK;
        end
      end
      bba_pkg::S_CHECK: begin
        if (stat.is_free) begin
          if (!stat.present) begin
            result_next = bba_pkg::ST_NULL_FREE;
            state_next  = bba_pkg::S_DONE;
          end else if (stat.size_small || stat.size_big) begin
            result_next = bba_pkg::ST_BAD_ORDER;
            state_next  = bba_pkg::S_DONE;
          end else begin
            state_next = bba_pkg::S_FREE;
          end
        end else if (stat.size_small) begin
          result_next = bba_pkg::ST_TOO_SMALL;
          state_next  = bba_pkg::S_DONE;
        end else if (stat.size_big) begin
          result_next = bba_pkg::ST_NONE_FREE;
          state_next  = bba_pkg::S_DONE;
        end else begin
          state_next = bba_pkg::S_SEARCH;
        end
      end
      bba_pkg::S_SEARCH: begin
        if (stat.head_nz) begin
          cmd.pop_rd = 1'b1;
          state_next = bba_pkg::S_POP;
        end else if (stat.lst_zero) begin
          result_next = bba_pkg::ST_NONE_FREE;
          state_next  = bba_pkg::S_DONE;
        end else begin
          cmd.step_up = 1'b1;
        end
      end
      bba_pkg::S_POP: begin
        cmd.pop_wr = 1'b1;
        if (stat.split_more) begin
          state_next = bba_pkg::S_SPLIT;
        end else begin
          result_next = bba_pkg::ST_ALLOCATED;
          state_next  = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_SPLIT: begin
        cmd.split = 1'b1;
        if (stat.last_split) begin
          result_next = bba_pkg::ST_ALLOCATED;
          state_next  = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_FREE: begin
        cmd.free_wr = 1'b1;
        result_next = bba_pkg::ST_FREED;
        state_next  = bba_pkg::S_DONE;
      end
      bba_pkg::S_DONE: begin
        if (stat.out_room) begin
          cmd.out_load = 1'b1;
          state_next   = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bba_pkg::S_IDLE;
      end
    endcase
    cmd.status = result;
  end

endmodule

// File: rtl/bba_dp.sv
// Datapath of the buddy block allocator core: list heads, link RAM, order
// walk and the output register. Depends on bba_pkg and bba_ram.
module bba_dp #(
  parameter int TOP_ORDER = 31,
  parameter int MIN_ORDER = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bba_pkg::dp_cmd_t                    cmd,
  output bba_pkg::dp_stat_t                   stat,
  input  logic [bba_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bba_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic [bba_pkg::STATUS_W-1:0]        m_axis_tuser
);

  localparam int UNIT_W    = TOP_ORDER - MIN_ORDER;
  localparam int LINK_W    = UNIT_W + 1;
  localparam int NUM_LISTS = UNIT_W + 1;
  localparam int NUM_UNITS = 2 ** UNIT_W;
  localparam int LST_W     = $clog2(NUM_LISTS);

  // Captured request.
  logic                        func_q;
  logic [bba_pkg::SIZE_W-1:0]  size_q;
  logic                        present_q;
  logic [UNIT_W-1:0]           unit;
  logic [LST_W-1:0]            lst;
  logic [LST_W-1:0]            lst_req;

  // Free-list heads, index 0 being the top order. A link is unit plus one.
  logic [LINK_W-1:0]           heads [NUM_LISTS];
  logic                        link0_written;
  logic                        zero_rd;

  logic [bba_pkg::SIZE_W-1:0]  in_size;
  logic [63:0]                 off_wide;
  logic [UNIT_W-1:0]           off_unit;
  logic [LST_W-1:0]            lst_rd;
  logic [LST_W-1:0]            lst_inc;
  logic [LINK_W-1:0]           head_rd;
  logic [LINK_W-1:0]           pop_link;
  logic [UNIT_W-1:0]           pop_unit;
  logic [LST_W-1:0]            shamt;
  logic [UNIT_W-1:0]           half;
  logic                        head_we;
  logic [LINK_W-1:0]           head_wdata;

  logic                        ram_we;
  logic [UNIT_W-1:0]           ram_waddr;
  logic [LINK_W-1:0]           ram_rdata;

  bba_pkg::status_t            status_q;
  logic [bba_pkg::OFFSET_W-1:0] granted;
  logic [63:0]                 grant_wide;

  assign in_size  = s_axis_tdata[5:0];
  assign off_wide = 64'(s_axis_tdata[36:6]) >> MIN_ORDER;
  assign off_unit = off_wide[UNIT_W-1:0];

  assign lst_inc  = lst + 1'b1;
  assign lst_rd   = cmd.split ? lst_inc : lst;
  assign head_rd  = (lst_rd <= LST_W'(NUM_LISTS - 1)) ? heads[lst_rd] : '0;
  assign pop_link = head_rd - 1'b1;
  assign pop_unit = pop_link[UNIT_W-1:0];

  // Upper half of the block being split at order TOP_ORDER - lst.
  assign shamt = LST_W'(UNIT_W - 1) - lst;
  assign half  = unit + (UNIT_W'(1) << shamt);

  assign ram_we    = cmd.split || cmd.free_wr;
  assign ram_waddr = cmd.split ? half : unit;

  assign head_we    = cmd.pop_wr || cmd.split || cmd.free_wr;
  always_comb begin
    if (cmd.pop_wr) begin
      head_wdata = zero_rd ? '0 : ram_rdata;
    end else if (cmd.split) begin
      head_wdata = LINK_W'(half) + 1'b1;
    end else begin
      head_wdata = LINK_W'(unit) + 1'b1;
    end
  end

  bba_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_UNITS)
  ) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (head_rd),
    .re    (cmd.pop_rd),
    .raddr (pop_unit),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q    <= s_axis_tuser[0];
      size_q    <= in_size;
      present_q <= s_axis_tdata[37];
      unit      <= off_unit;
      lst       <= LST_W'(6'(TOP_ORDER) - in_size);
      lst_req   <= LST_W'(6'(TOP_ORDER) - in_size);
    end else begin
      if (cmd.step_up) begin
        lst <= lst - 1'b1;
      end
      if (cmd.split) begin
        lst <= lst_inc;
      end
      if (cmd.pop_rd) begin
        unit <= pop_unit;
      end
    end
    if (cmd.pop_rd) begin
      zero_rd <= (pop_unit == '0) && !link0_written;
    end
  end

  // Heads and the written mark of link entry 0, the one entry with a reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        heads[i] <= (i == 0) ? LINK_W'(1) : '0;
      end
      link0_written <= 1'b0;
    end else begin
      if (head_we && (lst_rd <= LST_W'(NUM_LISTS - 1))) begin
        heads[lst_rd] <= head_wdata;
      end
      if (ram_we && (ram_waddr == '0)) begin
        link0_written <= 1'b1;
      end
    end
  end

  assign stat.is_free    = (func_q == bba_pkg::FUNC_FREE);
  assign stat.present    = present_q;
  assign stat.size_small = size_q < 6'(MIN_ORDER);
  assign stat.size_big   = size_q > 6'(TOP_ORDER);
  assign stat.head_nz    = (head_rd != '0);
  assign stat.lst_zero   = (lst == '0);
  assign stat.split_more = (lst != lst_req);
  assign stat.last_split = (lst_inc == lst_req);
  assign stat.out_room   = !m_axis_tvalid || m_axis_tready;

  assign grant_wide = 64'(unit) << MIN_ORDER;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_q <= cmd.status;
      granted  <= (cmd.status == bba_pkg::ST_ALLOCATED) ?
                  grant_wide[bba_pkg::OFFSET_W-1:0] : '0;
    end
  end

  assign m_axis_tdata = {1'b0, granted};
  assign m_axis_tuser = status_q;

endmodule

// File: rtl/buddy_block_allocator_core.sv
// Top level of the buddy block allocator core: controller plus datapath.
// Depends on bba_pkg, bba_ctrl, bba_dp and (through the datapath) bba_ram.
//
// Usage. Requests arrive one beat at a time on the s_axis channel: tuser
// selects allocate (0) or free (1), tdata carries the log2 size, the byte
// offset of a block being freed and a present flag. Every request yields
// exactly one result beat on m_axis: tuser is the status code, tdata the
// granted byte offset (zero unless the status is allocated).
// Sequencing. One request is in flight at a time. An allocate searches upward for a
// non-empty list, one order per cycle, visiting up to TOP_ORDER - MIN_ORDER + 1 orders,
// then pops its head and halves the block back down as needed (one halving per cycle);
// it reports none free when every list searched is empty. Each search step reads one
// list head, the step that finds a non-empty list also reads the link RAM, and each
// halving writes one list head and one link entry. The next request is taken the cycle
// after the result is loaded.
// Reset. The top-order list holds the whole region, all other lists are
// empty; no clearing pass is needed, the block is ready the cycle after rst.
// Stalls. The result sits in an output register; the core takes the next
// request while it waits and holds a later result until the register frees.
module buddy_block_allocator_core #(
  parameter int TOP_ORDER = 31,
  parameter int MIN_ORDER = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] size_log2, [36:6] block_offset, [37] block_present, [39:38] zero
  input  logic [39:0] s_axis_tdata,
  // [0] func
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [30:0] granted_offset, [31] zero
  output logic [31:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser
);

  bba_pkg::dp_cmd_t  cmd;
  bba_pkg::dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  bba_dp #(
    .TOP_ORDER (TOP_ORDER),
    .MIN_ORDER (MIN_ORDER)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Only one request is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request accepted while one is in flight");

  // Only an allocation reports an offset.
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != bba_pkg::ST_ALLOCATED) |-> m_axis_tdata == '0)
    else $error("offset reported with a non-allocated status");

  // Status codes stay within the defined set.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= bba_pkg::ST_BAD_ORDER)
    else $error("undefined status code on output");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat pending after reset");

endmodule
